### design/iafp_pkg.sv
// Shared types and constants for the IMU accelerometer frame parser.
package iafp_pkg;

   localparam int unsigned PAYLOAD_LEN_DEFAULT = 8;
   localparam int unsigned SCALE_W             = 18;
   localparam int unsigned RAW_W               = 16;
   localparam int unsigned SCALED_W            = 24;
   localparam int unsigned COUNT_W             = 32;

   localparam logic [7:0]         SYNC_BYTE   = 8'h55;
   localparam logic [7:0]         TAG_ACCEL   = 8'h51;
   localparam logic [7:0]         TAG_ANGLE   = 8'h53;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 18'd80281;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_TAG,
      PH_DATA
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_ACCEPT = 3'd1,
      EV_BADSUM = 3'd2,
      EV_ANGLE  = 3'd3,
      EV_OTHER  = 3'd4
   } event_type;

   typedef struct packed {
      event_type                  event_res;
      logic signed [RAW_W-1:0]    raw_x;
      logic signed [RAW_W-1:0]    raw_y;
      logic signed [RAW_W-1:0]    raw_z;
      logic        [COUNT_W-1:0]  accel_frames;
      logic        [COUNT_W-1:0]  angle_tags;
      logic        [COUNT_W-1:0]  other_tags;
      logic        [7:0]          recent_tag;
   } parse_result_type;

endpackage

### design/iafp_scale.sv
// One axis of raw-to-Q8.16 scaling: multiply, arithmetic shift by 8, saturate.
module iafp_scale (
   input  logic signed [iafp_pkg::RAW_W-1:0]    raw,
   input  logic        [iafp_pkg::SCALE_W-1:0]  scale,
   output logic signed [iafp_pkg::SCALED_W-1:0] scaled
);
   import iafp_pkg::*;

   localparam int unsigned PROD_W  = RAW_W + SCALE_W + 1;
   localparam int unsigned SHIFT_W = PROD_W - 8;

   logic signed [PROD_W-1:0]  product;
   logic signed [SHIFT_W-1:0] shifted;
   logic                      fits;

   assign product = PROD_W'(raw) * $signed({1'b0, scale});
   // The arithmetic shift rounds toward minus infinity.
   assign shifted = SHIFT_W'(product >>> 8);

   // The value fits when all bits above the result's sign bit copy it.
   assign fits = (shifted[SHIFT_W-1:SCALED_W-1] == '0) ||
                 (shifted[SHIFT_W-1:SCALED_W-1] == '1);

   always_comb begin
      if (fits) begin
         scaled = shifted[SCALED_W-1:0];
      end else if (shifted[SHIFT_W-1]) begin
         scaled = {1'b1, {(SCALED_W-1){1'b0}}};
      end else begin
         scaled = {1'b0, {(SCALED_W-1){1'b1}}};
      end
   end

endmodule

### design/iafp_parser.sv
// Byte parser: sync hunt, tag decode, payload capture, checksum and counters.
module iafp_parser #(
   parameter int unsigned PAYLOAD_LEN = iafp_pkg::PAYLOAD_LEN_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [7:0]                 rx_byte,
   output iafp_pkg::parse_result_type result
);
   import iafp_pkg::*;

   localparam int unsigned IDX_W = $clog2(PAYLOAD_LEN + 1);
   localparam int unsigned STORED = 6;

   phase_type          phase_ff, phase_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         tag_ff, tag_in;
   event_type          event_ff, event_in;
   logic [RAW_W-1:0]   raw_ff [3];
   logic [RAW_W-1:0]   raw_in [3];
   logic [COUNT_W-1:0] accel_cnt_ff, accel_cnt_in;
   logic [COUNT_W-1:0] angle_cnt_ff, angle_cnt_in;
   logic [COUNT_W-1:0] other_cnt_ff, other_cnt_in;
   logic [7:0]         payload_ff [STORED];
   logic               data_byte;

   assign data_byte = (phase_ff == PH_DATA) && (idx_ff < IDX_W'(PAYLOAD_LEN));

   always_comb begin
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      tag_in       = tag_ff;
      event_in     = EV_NONE;
      raw_in       = raw_ff;
      accel_cnt_in = accel_cnt_ff;
      angle_cnt_in = angle_cnt_ff;
      other_cnt_in = other_cnt_ff;
      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == SYNC_BYTE) begin
               phase_in = PH_TAG;
               sum_in   = SYNC_BYTE;
            end
         end
         PH_TAG: begin
            tag_in = rx_byte;
            sum_in = sum_ff + rx_byte;
            idx_in = '0;
            if (rx_byte == TAG_ACCEL) begin
               phase_in = PH_DATA;
            end else if (rx_byte == TAG_ANGLE) begin
               angle_cnt_in = angle_cnt_ff + 1'b1;
               event_in     = EV_ANGLE;
               phase_in     = PH_HUNT;
            end else begin
               other_cnt_in = other_cnt_ff + 1'b1;
               event_in     = EV_OTHER;
               phase_in     = PH_HUNT;
            end
         end
         PH_DATA: begin
            if (data_byte) begin
               sum_in = sum_ff + rx_byte;
               idx_in = idx_ff + 1'b1;
            end else begin
               // This is the check byte.
               if (sum_ff == rx_byte) begin
                  for (int i = 0; i < 3; i++) begin
                     raw_in[i] = {payload_ff[2*i+1], payload_ff[2*i]};
                  end
                  accel_cnt_in = accel_cnt_ff + 1'b1;
                  event_in     = EV_ACCEPT;
               end else begin
                  event_in = EV_BADSUM;
               end
               phase_in = PH_HUNT;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         idx_ff       <= '0;
         sum_ff       <= '0;
         tag_ff       <= '0;
         event_ff     <= EV_NONE;
         raw_ff       <= '{default: '0};
         accel_cnt_ff <= '0;
         angle_cnt_ff <= '0;
         other_cnt_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         tag_ff       <= tag_in;
         event_ff     <= event_in;
         raw_ff       <= raw_in;
         accel_cnt_ff <= accel_cnt_in;
         angle_cnt_ff <= angle_cnt_in;
         other_cnt_ff <= other_cnt_in;
      end
   end

   // Only the first six data bytes carry the three axes; later ones are summed only.
   always_ff @(posedge clock) begin
      if (accept && data_byte) begin
         for (int i = 0; i < STORED; i++) begin
            if (idx_ff == IDX_W'(i)) begin
               payload_ff[i] <= rx_byte;
            end
         end
      end
   end

   assign result.event_res    = event_ff;
   assign result.raw_x        = raw_ff[0];
   assign result.raw_y        = raw_ff[1];
   assign result.raw_z        = raw_ff[2];
   assign result.accel_frames = accel_cnt_ff;
   assign result.angle_tags   = angle_cnt_ff;
   assign result.other_tags   = other_cnt_ff;
   assign result.recent_tag   = tag_ff;

   a_accept_counts : assert property (@(posedge clock) disable iff (reset)
      accept && (event_in == EV_ACCEPT) |=> accel_cnt_ff == $past(accel_cnt_ff) + 1'b1)
      else $error("accepted frame did not advance the frame count");

   a_counters_hold : assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(accel_cnt_ff) && $stable(angle_cnt_ff) && $stable(other_cnt_ff))
      else $error("counter changed without an accepted item");

   a_index_range : assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(PAYLOAD_LEN))
      else $error("byte index ran past the payload length");

   a_sync_seed : assert property (@(posedge clock) disable iff (reset)
      accept && (phase_ff == PH_HUNT) && (rx_byte == SYNC_BYTE)
      |=> (phase_ff == PH_TAG) && (sum_ff == SYNC_BYTE))
      else $error("sync byte did not start a frame with a seeded sum");

endmodule

### design/imu_accel_frame_parser.sv
// Top level of the IMU accelerometer frame parser: handshakes, scale register, scaling stage.
// An accepted byte's result is registered in the parser stage, then passes through
// the combinational scaling stage into the result register.
// Throughput: one byte per cycle; the two stages advance independently, so a stalled
// result only holds up input once both stages are full.
// Reset: parser returns to sync hunt, counters, latched axes and recent tag clear to
// zero, and the scale register returns to 80281.
module imu_accel_frame_parser #(
   parameter int unsigned PAYLOAD_LEN = iafp_pkg::PAYLOAD_LEN_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_event_res,
   output logic signed [iafp_pkg::RAW_W-1:0]    rsp_raw_x,
   output logic signed [iafp_pkg::RAW_W-1:0]    rsp_raw_y,
   output logic signed [iafp_pkg::RAW_W-1:0]    rsp_raw_z,
   output logic signed [iafp_pkg::SCALED_W-1:0] rsp_scaled_x,
   output logic signed [iafp_pkg::SCALED_W-1:0] rsp_scaled_y,
   output logic signed [iafp_pkg::SCALED_W-1:0] rsp_scaled_z,
   output logic [iafp_pkg::COUNT_W-1:0]         rsp_accel_frames,
   output logic [iafp_pkg::COUNT_W-1:0]         rsp_angle_tags,
   output logic [iafp_pkg::COUNT_W-1:0]         rsp_other_tags,
   output logic [7:0]                           rsp_recent_tag,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [iafp_pkg::SCALE_W-1:0]         csr_accel_scale
);
   import iafp_pkg::*;

   logic                       scale_write;
   logic [SCALE_W-1:0]         accel_scale_ff;
   logic                       stage_valid_ff;
   logic                       rsp_valid_ff;
   logic                       out_adv;
   logic                       stage_adv;
   logic                       accept;
   parse_result_type           parsed;
   parse_result_type           rsp_ff;
   logic signed [SCALED_W-1:0] scaled_in [3];
   logic signed [SCALED_W-1:0] scaled_ff [3];

   assign out_adv     = !rsp_valid_ff || !rsp_stall;
   assign stage_adv   = !stage_valid_ff || out_adv;
   assign req_stall   = !stage_adv;
   assign accept      = req_valid && stage_adv;
   assign csr_ready   = 1'b1;
   assign scale_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_scale_ff <= SCALE_RESET;
      end else if (scale_write) begin
         accel_scale_ff <= csr_accel_scale;
      end
   end

   iafp_parser #(
      .PAYLOAD_LEN (PAYLOAD_LEN)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .result  (parsed)
   );

   iafp_scale u_scale_x (.raw(parsed.raw_x), .scale(accel_scale_ff), .scaled(scaled_in[0]));
   iafp_scale u_scale_y (.raw(parsed.raw_y), .scale(accel_scale_ff), .scaled(scaled_in[1]));
   iafp_scale u_scale_z (.raw(parsed.raw_z), .scale(accel_scale_ff), .scaled(scaled_in[2]));

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (stage_adv) begin
            stage_valid_ff <= accept;
         end
         if (out_adv) begin
            rsp_valid_ff <= stage_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && stage_valid_ff) begin
         rsp_ff    <= parsed;
         scaled_ff <= scaled_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = rsp_ff.event_res;
   assign rsp_raw_x        = rsp_ff.raw_x;
   assign rsp_raw_y        = rsp_ff.raw_y;
   assign rsp_raw_z        = rsp_ff.raw_z;
   assign rsp_scaled_x     = scaled_ff[0];
   assign rsp_scaled_y     = scaled_ff[1];
   assign rsp_scaled_z     = scaled_ff[2];
   assign rsp_accel_frames = rsp_ff.accel_frames;
   assign rsp_angle_tags   = rsp_ff.angle_tags;
   assign rsp_other_tags   = rsp_ff.other_tags;
   assign rsp_recent_tag   = rsp_ff.recent_tag;

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("input taken while both stages were full");

   a_stage_moves : assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("parsed item did not move to the result register");

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      accept |=> stage_valid_ff)
      else $error("accepted item was lost before the scaling stage");

endmodule
